FILE: rtl/core/text_stream_visualizer_macros.svh
// assertion macros used by the checker of the text stream visualizer
`ifndef TEXT_STREAM_VISUALIZER_MACROS_SVH
`define TEXT_STREAM_VISUALIZER_MACROS_SVH

// condition that must hold at every clock edge outside reset
`define TSV_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence checked in the same cycle as the antecedent
`define TSV_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define TSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/tsv_pkg.sv
// shared types and constants of the text stream visualizer
package tsv_pkg;

  localparam int COUNT_DIGITS = 8;
  localparam int NUM_WIDTH    = 6;
  localparam int BODY_MAX     = 4;
  localparam int COUNT_W      = 4 * COUNT_DIGITS;
  localparam int SLOTS        = COUNT_DIGITS + 1 + BODY_MAX;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int BLEN_W       = $clog2(BODY_MAX + 1);
  localparam int CFG_IDX_W    = 3;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CTRL_BIT = 8'h40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_LINES     = 3'd0,
    CFG_NUMBER_NONBLANK  = 3'd1,
    CFG_SQUEEZE_BLANK    = 3'd2,
    CFG_SHOW_ENDS        = 3'd3,
    CFG_SHOW_TABS        = 3'd4,
    CFG_SHOW_NONPRINTING = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } tsv_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } tsv_result_t;

endpackage

FILE: rtl/core/text_stream_visualizer.sv
// top level of the text stream visualizer: cat-style line numbering and escaping
//
// Takes one stream byte per transfer on the item channel and returns the
// transformed bytes, one per transfer, on the result channel; last_of_run marks
// the final byte that an input byte caused. An input byte expands at once into
// a small slot buffer (line number field, tab, then up to four body bytes such
// as M-^X), which drains one byte per cycle into the result register unless the
// result channel stalls. A byte that gives one result byte therefore flows at one
// byte per cycle; a byte that gives n result bytes holds the item channel until
// its last result byte leaves the buffer (n is at most 13: up to eight digits and
// a tab of number prefix plus four body bytes). The first result byte passes from
// the slot buffer into the result register before it is presented. A squeezed
// empty line is taken without entering the buffer and gives no result. The
// buffer's single read port is what sets the rate. Configuration writes are
// taken at any time (cfg_ready is always high) and should only come while the
// block is idle. Reset is synchronous and active high.
module text_stream_visualizer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  tsv_pkg::tsv_item_t                item,
  output logic                              result_valid,
  input  logic                              result_stall,
  output tsv_pkg::tsv_result_t              result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tsv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic                              cfg_data
);
  import tsv_pkg::*;

  // saturating bcd increment, ripple over the digits
  function automatic logic [COUNT_W-1:0] bcd_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    logic               carry;
    logic               all9;
    logic [3:0]         d;
    r     = '0;
    carry = 1'b1;
    all9  = 1'b1;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (d != 4'd9) begin
        all9 = 1'b0;
      end
      if (carry && d >= 4'd9) begin
        d = 4'd0;
      end else if (carry) begin
        d     = d + 4'd1;
        carry = 1'b0;
      end
      r[4*i +: 4] = d;
    end
    return all9 ? v : r;
  endfunction

  // configuration registers
  logic number_lines;
  logic number_nonblank_only;
  logic squeeze_blank;
  logic show_ends;
  logic show_tabs;
  logic show_nonprinting;

  // line state
  logic               at_line_start;
  logic               blank_squeezing;
  logic [COUNT_W-1:0] line_count;
  logic               at_line_start_next;
  logic               blank_squeezing_next;
  logic [COUNT_W-1:0] line_count_next;

  // expansion buffer and its read pointer
  logic [7:0]       slots [SLOTS];
  logic [7:0]       slots_next [SLOTS];
  logic             buf_valid;
  logic [IDX_W-1:0] rd_pos;
  logic [IDX_W-1:0] end_pos;
  logic [IDX_W-1:0] start_next;
  logic [IDX_W-1:0] end_next;

  // per item decode
  logic               item_xfer;
  logic               out_free;
  logic               buf_last;
  logic [7:0]         ch;
  logic [7:0]         low;
  logic               is_lf;
  logic               is_ctl;
  logic [7:0]         caret_ch;
  logic               als_eff;
  logic               sq_eff;
  logic [COUNT_W-1:0] cnt_eff;
  logic [COUNT_W-1:0] cnt_inc;
  logic               drop;
  logic               num_en;
  logic [7:0]         body [BODY_MAX];
  logic [BLEN_W-1:0]  body_len;
  logic [IDX_W-1:0]   top;
  logic [IDX_W-1:0]   num_len;
  logic [3:0]         dig;

  assign cfg_ready = 1'b1;

  // result register is free when empty or when its byte is being taken
  assign out_free   = !result_valid || !result_stall;
  assign buf_last   = rd_pos == end_pos;
  // take a new byte when the buffer is empty or hands over its last byte now
  assign item_stall = buf_valid && !(buf_last && out_free);
  assign item_xfer  = item_valid && !item_stall;

  // file_start restarts line state ahead of this byte
  assign ch      = item.data_byte;
  assign low     = {1'b0, ch[6:0]};
  assign is_lf   = ch == CH_LF;
  assign als_eff = item.file_start || at_line_start;
  assign sq_eff  = !item.file_start && blank_squeezing;
  assign cnt_eff = item.file_start ? '0 : line_count;
  assign cnt_inc = bcd_inc(cnt_eff);

  // extra empty line while squeezing gives nothing
  assign drop   = als_eff && squeeze_blank && is_lf && sq_eff;
  assign num_en = als_eff && !drop && number_lines && (!number_nonblank_only || !is_lf);

  assign line_count_next      = num_en ? cnt_inc : cnt_eff;
  assign blank_squeezing_next = (als_eff && squeeze_blank) ? is_lf : sq_eff;
  // a high line feed shown as M-^J also ends the line
  assign at_line_start_next   = is_lf || (show_nonprinting && ch[7] && low == CH_LF);

  assign is_ctl   = low < CH_SPACE || low == CH_DEL;
  assign caret_ch = (low == CH_DEL) ? CH_QUEST : (low | CTRL_BIT);

  // body bytes, left aligned
  always_comb begin
    for (int b = 0; b < BODY_MAX; b++) begin
      body[b] = '0;
    end
    body_len = BLEN_W'(1);
    if (is_lf) begin
      if (show_ends) begin
        body[0]  = CH_DOLLAR;
        body[1]  = CH_LF;
        body_len = BLEN_W'(2);
      end else begin
        body[0] = CH_LF;
      end
    end else if (ch == CH_TAB && show_tabs) begin
      body[0]  = CH_CARET;
      body[1]  = CH_I;
      body_len = BLEN_W'(2);
    end else if (ch != CH_TAB && show_nonprinting) begin
      if (ch[7]) begin
        body[0]  = CH_M;
        body[1]  = CH_MINUS;
        body[2]  = is_ctl ? CH_CARET : low;
        body[3]  = caret_ch;
        body_len = is_ctl ? BLEN_W'(4) : BLEN_W'(3);
      end else begin
        body[0]  = is_ctl ? CH_CARET : low;
        body[1]  = caret_ch;
        body_len = is_ctl ? BLEN_W'(2) : BLEN_W'(1);
      end
    end else begin
      body[0] = ch;
    end
  end

  // highest nonzero digit of the new count
  always_comb begin
    top = '0;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (cnt_inc[4*i +: 4] != 4'd0) begin
        top = IDX_W'(i);
      end
    end
    num_len = (top + IDX_W'(1) > IDX_W'(NUM_WIDTH)) ? top + IDX_W'(1) : IDX_W'(NUM_WIDTH);
  end

  // fixed slot layout: digit field, tab, body; the used slots are contiguous
  always_comb begin
    dig = '0;
    for (int j = 0; j < COUNT_DIGITS; j++) begin
      dig = cnt_inc[4*(COUNT_DIGITS-1-j) +: 4];
      if (dig > 4'd9) begin
        dig = 4'd9;
      end
      slots_next[j] = (IDX_W'(COUNT_DIGITS-1-j) > top) ? CH_SPACE : CH_ZERO + 8'(dig);
    end
    slots_next[COUNT_DIGITS] = CH_TAB;
    for (int b = 0; b < BODY_MAX; b++) begin
      slots_next[COUNT_DIGITS+1+b] = body[b];
    end
  end

  assign start_next = num_en ? IDX_W'(COUNT_DIGITS) - num_len : IDX_W'(COUNT_DIGITS+1);
  assign end_next   = IDX_W'(COUNT_DIGITS) + IDX_W'(body_len);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      number_lines         <= 1'b0;
      number_nonblank_only <= 1'b0;
      squeeze_blank        <= 1'b0;
      show_ends            <= 1'b0;
      show_tabs            <= 1'b0;
      show_nonprinting     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUMBER_LINES:     number_lines         <= cfg_data;
        CFG_NUMBER_NONBLANK:  number_nonblank_only <= cfg_data;
        CFG_SQUEEZE_BLANK:    squeeze_blank        <= cfg_data;
        CFG_SHOW_ENDS:        show_ends            <= cfg_data;
        CFG_SHOW_TABS:        show_tabs            <= cfg_data;
        CFG_SHOW_NONPRINTING: show_nonprinting     <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start   <= 1'b1;
      blank_squeezing <= 1'b0;
      line_count      <= '0;
      buf_valid       <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      if (item_xfer) begin
        at_line_start   <= at_line_start_next;
        blank_squeezing <= blank_squeezing_next;
        line_count      <= line_count_next;
      end
      if (out_free) begin
        result_valid <= buf_valid;
      end
      if (item_xfer && !drop) begin
        buf_valid <= 1'b1;
      end else if (out_free && buf_valid && buf_last) begin
        buf_valid <= 1'b0;
      end
    end
  end

  // payload: buffer contents, pointers and the result register
  always_ff @(posedge clk) begin
    if (out_free && buf_valid) begin
      result.out_byte    <= slots[rd_pos];
      result.last_of_run <= buf_last;
    end
    // a new byte only lands when the buffer is empty or while its last byte leaves
    if (item_xfer && !drop) begin
      slots   <= slots_next;
      rd_pos  <= start_next;
      end_pos <= end_next;
    end else if (out_free && buf_valid) begin
      rd_pos <= rd_pos + IDX_W'(1);
    end
  end

endmodule

FILE: rtl/core/tsv_checker.sv
// port-level checks of the text stream visualizer and their bind
`include "text_stream_visualizer_macros.svh"

module tsv_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input tsv_pkg::tsv_result_t result,
  input logic                 cfg_valid,
  input logic                 cfg_ready
);
  import tsv_pkg::*;

  // a stalled result holds
  `TSV_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

  // a run that is not finished keeps the result channel busy
  `TSV_ASSERT_NEXT(a_run_continues, result_valid && !result_stall && !result.last_of_run, result_valid, "gap inside a run")

  // reset leaves both channels empty and open
  `TSV_ASSERT_SAME(a_reset_clear, $past(rst), !result_valid && !item_stall, "not idle after reset")

  // configuration is never refused
  `TSV_ASSERT_ALWAYS(a_cfg_ready, !cfg_valid || cfg_ready, "config write refused")

endmodule

bind text_stream_visualizer tsv_checker u_tsv_checker (.*);

FILE: dv/tb_text_stream_visualizer.sv
// self-checking testbench of the text stream visualizer with its own cat-style predictor
`timescale 1ns / 1ps

module tb_text_stream_visualizer;
  import tsv_pkg::*;

  localparam int NUM_REGS = 6;

  // one mode bit per configuration register, placed at its register index
  localparam logic [NUM_REGS-1:0] M_NUMBER   = 6'd1 << CFG_NUMBER_LINES;
  localparam logic [NUM_REGS-1:0] M_NONBLANK = 6'd1 << CFG_NUMBER_NONBLANK;
  localparam logic [NUM_REGS-1:0] M_SQUEEZE  = 6'd1 << CFG_SQUEEZE_BLANK;
  localparam logic [NUM_REGS-1:0] M_ENDS     = 6'd1 << CFG_SHOW_ENDS;
  localparam logic [NUM_REGS-1:0] M_TABS     = 6'd1 << CFG_SHOW_TABS;
  localparam logic [NUM_REGS-1:0] M_NONPRINT = 6'd1 << CFG_SHOW_NONPRINTING;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  tsv_item_t            item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  tsv_result_t          result;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic                 cfg_data     = 1'b0;

  // stream bytes waiting for the driver, and output bytes still owed by the block
  tsv_item_t   pending_items[$];
  tsv_result_t expected_out[$];

  // predictor copy of the configuration and of the line state
  logic [NUM_REGS-1:0] mode = '0;
  logic                line_start = 1'b1;
  logic                squeezing  = 1'b0;
  logic [COUNT_W-1:0]  line_bcd   = '0;

  logic item_taken   = 1'b0;
  logic result_taken = 1'b0;
  int   send_gap     = 0;
  int   stall_left   = 0;
  bit   quiet        = 1'b0;   // no idling on either side while set
  int   failures     = 0;

  text_stream_visualizer u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // idle cycles before the next transfer on either side
  function automatic int wait_draw();
    if (quiet) return 0;
    return $urandom_range(0, 19);
  endfunction

  // BCD line counter, sticks at all nines
  function automatic void bump_line_count();
    logic carry;
    if (line_bcd == {COUNT_DIGITS{4'h9}}) return;
    carry = 1'b1;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (carry) begin
        if (line_bcd[4*i +: 4] == 4'h9) begin
          line_bcd[4*i +: 4] = 4'h0;
        end else begin
          line_bcd[4*i +: 4] = line_bcd[4*i +: 4] + 4'h1;
          carry = 1'b0;
        end
      end
    end
  endfunction

  // expand one accepted stream byte into the output bytes it must produce
  function automatic void expand_byte(tsv_item_t it);
    logic [7:0]  ch;
    logic [7:0]  run[$];
    int          top;
    tsv_result_t r;
    ch = it.data_byte;
    // a new file restarts numbering and line state before its first byte
    if (it.file_start) begin
      line_bcd   = '0;
      squeezing  = 1'b0;
      line_start = 1'b1;
    end
    if (line_start) begin
      if (mode[CFG_SQUEEZE_BLANK]) begin
        if (ch == CH_LF) begin
          // an extra empty line while squeezing vanishes, line state unchanged
          if (squeezing) return;
          squeezing = 1'b1;
        end else begin
          squeezing = 1'b0;
        end
      end
      if (mode[CFG_NUMBER_LINES] && (!mode[CFG_NUMBER_NONBLANK] || ch != CH_LF)) begin
        bump_line_count();
        // highest nonzero digit sets the printed width; pad to six
        top = 0;
        for (int i = 0; i < COUNT_DIGITS; i++)
          if (line_bcd[4*i +: 4] != 4'h0) top = i;
        for (int i = top + 1; i < NUM_WIDTH; i++) run.push_back(CH_SPACE);
        for (int i = top; i >= 0; i--) run.push_back(CH_ZERO + line_bcd[4*i +: 4]);
        run.push_back(CH_TAB);
      end
    end
    if (ch == CH_LF) begin
      if (mode[CFG_SHOW_ENDS]) run.push_back(CH_DOLLAR);
      run.push_back(ch);
    end else if (ch == CH_TAB && mode[CFG_SHOW_TABS]) begin
      run.push_back(CH_CARET);
      run.push_back(CH_I);
    end else if (ch != CH_TAB && mode[CFG_SHOW_NONPRINTING]) begin
      if (ch[7]) begin
        run.push_back(CH_M);
        run.push_back(CH_MINUS);
        ch[7] = 1'b0;
      end
      if (ch < CH_SPACE || ch == CH_DEL) begin
        run.push_back(CH_CARET);
        run.push_back(ch == CH_DEL ? CH_QUEST : (ch | CTRL_BIT));
      end else begin
        run.push_back(ch);
      end
    end else begin
      run.push_back(ch);
    end
    // a high line feed counts as a line end too, since the low bits are kept
    line_start = (ch == CH_LF);
    foreach (run[i]) begin
      r.out_byte    = run[i];
      r.last_of_run = (i == run.size() - 1);
      expected_out.push_back(r);
    end
  endfunction

  // item driver: presents the next queued byte at the falling edge after its gap
  always @(negedge clk) begin : item_driver
    tsv_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!(item_valid && !item_taken)) begin
      if (send_gap > 0 || pending_items.size() == 0) begin
        item_valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        nxt = pending_items.pop_front();
        item       <= nxt;
        item_valid <= 1'b1;
        send_gap   <= wait_draw();
      end
    end
  end

  // result side: after every transfer, stall for a freshly drawn number of cycles
  always @(negedge clk) begin : result_sink
    int w;
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else begin
      w = result_taken ? wait_draw() : stall_left;
      result_stall <= (w > 0);
      stall_left   <= (w > 0) ? w - 1 : 0;
    end
  end

  // monitor: predicts on every item transfer, compares every result transfer
  always @(posedge clk) begin : result_monitor
    tsv_result_t want;
    if (rst) begin
      item_taken   <= 1'b0;
      result_taken <= 1'b0;
    end else begin
      item_taken   <= item_valid && !item_stall;
      result_taken <= result_valid && !result_stall;
      if (item_valid && !item_stall) expand_byte(item);
      if (result_valid && !result_stall) begin
        if (expected_out.size() == 0) begin
          $error("unexpected result byte %02h last_of_run %0b",
                 result.out_byte, result.last_of_run);
          failures++;
        end else begin
          want = expected_out.pop_front();
          if (result.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, result.out_byte);
            failures++;
          end
          if (result.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   want.last_of_run, result.last_of_run);
            failures++;
          end
        end
      end
    end
  end

  task automatic queue_byte(logic [7:0] b, logic fs);
    tsv_item_t it;
    it.data_byte  = b;
    it.file_start = fs;
    pending_items.push_back(it);
  endtask

  // writes all six registers back to back; only called while the block is idle
  task automatic apply_mode(logic [NUM_REGS-1:0] m);
    for (int r = 0; r < NUM_REGS; r++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= cfg_reg_t'(r);
      cfg_data  <= m[r];
      do @(posedge clk); while (!cfg_ready);
      mode[r] = m[r];
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait until every queued byte went in and every owed byte came out
  task automatic settle_down();
    int spins;
    spins = 0;
    while ((pending_items.size() != 0 || item_valid || expected_out.size() != 0)
           && spins < 50000) begin
      @(posedge clk);
      spins++;
    end
    // a squeezed line gives no result but may still be in flight
    repeat (4) @(posedge clk);
  endtask

  // printable text with tabs, controls, delete and high bytes mixed in
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 9))
      0:       return CH_TAB;
      1:       return 8'($urandom_range(0, 31));
      2:       return 8'($urandom_range(128, 255));
      3:       return CH_DEL;
      default: return 8'($urandom_range(32, 126));
    endcase
  endfunction

  initial begin : stimulus
    logic [NUM_REGS-1:0] m;
    int                  n;
    int                  len;
    logic                fs;
    bit                  held;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // plain pass-through after reset: extremes of the byte range
    apply_mode('0);
    queue_byte("a", 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte(CH_TAB, 1'b0);
    settle_down();

    // every feature on except non-blank numbering
    apply_mode(M_NUMBER | M_SQUEEZE | M_ENDS | M_TABS | M_NONPRINT);
    queue_byte("A", 1'b1);
    queue_byte(CH_TAB, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte(CH_LF, 1'b0);     // squeezed away
    queue_byte(CH_DEL, 1'b0);
    queue_byte(8'h8A, 1'b0);     // high line feed ends the line
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h1F, 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte("x", 1'b1);       // new file, numbering restarts
    queue_byte(8'h7E, 1'b0);
    settle_down();

    // non-blank numbering leaves empty lines unnumbered
    apply_mode(M_NUMBER | M_NONBLANK);
    queue_byte(CH_LF, 1'b0);
    queue_byte("b", 1'b0);
    queue_byte(CH_LF, 1'b0);
    queue_byte(CH_LF, 1'b0);
    settle_down();

    // ends and tabs marked without non-printing escapes
    apply_mode(M_ENDS | M_TABS);
    queue_byte(CH_TAB, 1'b0);
    queue_byte(CH_LF, 1'b0);
    settle_down();

    // random lines under a range of settings, all-on and all-off first
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)      m = '1;
      else if (ph == 1) m = '0;
      else              m = NUM_REGS'($urandom_range(0, 63));
      apply_mode(m);
      quiet = (ph % 3 == 2);
      held  = 1'b0;
      n     = 0;
      while (n < 13) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any byte, any file flag
          queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
          n++;
        end else begin
          // a well-formed line, sometimes empty, sometimes opening a new file
          fs  = ($urandom_range(0, 7) == 0);
          len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          for (int k = 0; k < len; k++) begin
            queue_byte(text_byte(), fs && k == 0);
            n++;
          end
          queue_byte(($urandom_range(0, 7) == 0) ? 8'h8A : CH_LF, fs && len == 0);
          n++;
        end
        // sender holds off mid-phase until the block has drained
        if (ph == 3 && n >= 9 && !held) begin
          settle_down();
          held = 1'b1;
        end
      end
      settle_down();
    end

    if (expected_out.size() != 0) begin
      $error("%0d result bytes never came", expected_out.size());
      failures++;
    end
    if (failures == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: text_stream_visualizer.f
+incdir+rtl/core
rtl/core/tsv_pkg.sv
rtl/core/text_stream_visualizer.sv
rtl/core/tsv_checker.sv
dv/tb_text_stream_visualizer.sv
